@@ rtl/lru_pkg.sv @@
`default_nettype none

package lru_pkg;

	// Width and reset value of the frames-in-use register.
	localparam int unsigned CFG_W = 4;
	localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

	// Width of the running hit and fault counters.
	localparam int unsigned COUNT_W = 16;

	// Search record handed from cell to cell, at the default sizes
	// (eight frames, eight-bit pages). The top level passes its own sized copy.
	typedef struct packed {
		logic       hit_found;
		logic [2:0] hit_idx;
		logic [2:0] hit_rank;
		logic       empty_found;
		logic [2:0] empty_idx;
		logic       best_found;
		logic [2:0] best_rank;
		logic [2:0] best_idx;
		logic [7:0] best_page;
	} scan_def_t;

	// Update command broadcast to every cell, at the default sizes.
	typedef struct packed {
		logic       en;
		logic [2:0] tgt;
		logic       age_all;
		logic [2:0] limit;
		logic       write_page;
	} upd_def_t;

endpackage

`default_nettype wire

@@ rtl/lru_req_if.sv @@
`default_nettype none

// Request channel: one page reference per request.
interface lru_req_if #(
	parameter int PAGE_BITS = 8
);
	logic                 valid;
	logic                 ready;
	logic [PAGE_BITS-1:0] page;

	modport source (output valid, output page, input ready);
	modport sink (input valid, input page, output ready);
endinterface

`default_nettype wire

@@ rtl/lru_rsp_if.sv @@
`default_nettype none

// Result channel: one result per page reference.
interface lru_rsp_if
	import lru_pkg::*;
#(
	parameter int PAGE_BITS = 8,
	parameter int FRAME_W   = 3
);
	logic                 valid;
	logic                 ready;
	logic                 hit;
	logic [FRAME_W-1:0]   frame;
	logic                 evicted_valid;
	logic [PAGE_BITS-1:0] evicted_page;
	logic [COUNT_W-1:0]   hit_count;
	logic [COUNT_W-1:0]   fault_count;

	modport source (
		output valid, output hit, output frame, output evicted_valid,
		output evicted_page, output hit_count, output fault_count,
		input ready
	);
	modport sink (
		input valid, input hit, input frame, input evicted_valid,
		input evicted_page, input hit_count, input fault_count,
		output ready
	);
endinterface

`default_nettype wire

@@ rtl/lru_cell.sv @@
`default_nettype none

// One page frame: page number, valid bit and recency rank (0 is most recent).
// The cell folds its own state into the search record coming from the
// lower-numbered neighbor and passes it on, and applies the broadcast update.
module lru_cell
	import lru_pkg::*;
#(
	parameter int FRAMES    = 8,
	parameter int PAGE_BITS = 8,
	parameter int CELL_IDX  = 0,
	parameter type scan_t   = scan_def_t,
	parameter type upd_t    = upd_def_t
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_use,
	input  logic [PAGE_BITS-1:0] page,
	input  scan_t                scan_in,
	output scan_t                scan_out,
	input  upd_t                 upd
);

	localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam logic [IDX_W-1:0] MY_IDX   = IDX_W'(CELL_IDX);
	localparam logic [IDX_W-1:0] RANK_MAX = IDX_W'(FRAMES - 1);

	logic [PAGE_BITS-1:0] page_q;
	logic                 valid_q;
	logic [IDX_W-1:0]     rank_q;
	logic                 match;
	logic                 ages;

	assign match = in_use && valid_q && (page_q == page);

	// Fold this frame into the search: first match, first empty frame, oldest rank.
	always_comb begin
		scan_out = scan_in;
		if (!scan_in.hit_found && match) begin
			scan_out.hit_found = 1'b1;
			scan_out.hit_idx   = MY_IDX;
			scan_out.hit_rank  = rank_q;
		end
		if (!scan_in.empty_found && in_use && !valid_q) begin
			scan_out.empty_found = 1'b1;
			scan_out.empty_idx   = MY_IDX;
		end
		if (in_use && (!scan_in.best_found || rank_q > scan_in.best_rank)) begin
			scan_out.best_found = 1'b1;
			scan_out.best_rank  = rank_q;
			scan_out.best_idx   = MY_IDX;
			scan_out.best_page  = page_q;
		end
	end

	// A valid frame in use ages when it was more recent than the touched frame.
	assign ages = in_use && valid_q && (upd.age_all || rank_q < upd.limit) &&
		(rank_q != RANK_MAX);

	// Valid bit and rank.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else if (upd.en) begin
			if (upd.tgt == MY_IDX) begin
				rank_q <= '0;
				if (upd.write_page) begin
					valid_q <= 1'b1;
				end
			end else if (ages) begin
				rank_q <= rank_q + 1'b1;
			end
		end
	end

	// Page number, read only while the frame is valid.
	always_ff @(posedge clk) begin
		if (upd.en && upd.write_page && upd.tgt == MY_IDX) begin
			page_q <= page;
		end
	end

endmodule

`default_nettype wire

@@ rtl/lru_page_replacement.sv @@
`default_nettype none

// Channel  Role    Handshake      Payload
// req      sink    valid/ready    page
// rsp      source  valid/ready    hit, frame, evicted_valid, evicted_page,
//                                 hit_count, fault_count
// cfg      write   cfg_we         cfg_wdata (frames in use)
//
// One request per cycle is taken while the lookup stage is empty or moving. Its result
// passes from the lookup stage into the result register and is valid from then on.
// The rate is set by the frame cell chain, which searches and updates in the same cycle.
// Reset clears all valid bits, ranks and counters and sets frames in use to 8;
// there is no clearing pass. A stalled result holds the stage behind it, and a
// request is taken whenever that stage is empty or moving.
module lru_page_replacement
	import lru_pkg::*;
#(
	parameter int FRAMES    = 8,
	parameter int PAGE_BITS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	lru_req_if.sink          req,
	lru_rsp_if.source        rsp
);

	localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

	typedef struct packed {
		logic                 hit_found;
		logic [IDX_W-1:0]     hit_idx;
		logic [IDX_W-1:0]     hit_rank;
		logic                 empty_found;
		logic [IDX_W-1:0]     empty_idx;
		logic                 best_found;
		logic [IDX_W-1:0]     best_rank;
		logic [IDX_W-1:0]     best_idx;
		logic [PAGE_BITS-1:0] best_page;
	} scan_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] tgt;
		logic             age_all;
		logic [IDX_W-1:0] limit;
		logic             write_page;
	} upd_t;

	logic [CFG_W-1:0]     frames_q;
	logic                 valid_s1;
	logic [PAGE_BITS-1:0] page_s1;
	logic                 out_free;
	logic                 fire;
	logic [FRAMES-1:0]    in_use;
	scan_t                chain [FRAMES+1];
	scan_t                last;
	upd_t                 upd;
	logic                 is_hit;
	logic                 evict;
	logic [IDX_W-1:0]     tgt;
	logic [COUNT_W-1:0]   hit_cnt_q;
	logic [COUNT_W-1:0]   fault_cnt_q;
	logic [COUNT_W-1:0]   hit_cnt_next;
	logic [COUNT_W-1:0]   fault_cnt_next;

	logic                 rsp_valid_q;
	logic                 rsp_hit_q;
	logic [IDX_W-1:0]     rsp_frame_q;
	logic                 rsp_ev_valid_q;
	logic [PAGE_BITS-1:0] rsp_ev_page_q;

	// Frames-in-use register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= CFG_RESET;
		end else if (cfg_we) begin
			frames_q <= cfg_wdata;
		end
	end

	// Frame 0 always takes part; a count above FRAMES covers every frame.
	always_comb begin
		for (int i = 0; i < FRAMES; i++) begin
			in_use[i] = (i == 0) || (32'(frames_q) > i);
		end
	end

	// Handshake: the lookup stage moves when the result register is free.
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign fire      = valid_s1 && out_free;
	assign req.ready = !valid_s1 || out_free;

	// Lookup stage holds the referenced page.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			page_s1 <= req.page;
		end
	end

	// Frame cell chain, searched from frame 0 upward.
	assign chain[0] = '0;

	for (genvar g = 0; g < FRAMES; g++) begin : g_cell
		lru_cell #(
			.FRAMES    (FRAMES),
			.PAGE_BITS (PAGE_BITS),
			.CELL_IDX  (g),
			.scan_t    (scan_t),
			.upd_t     (upd_t)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_use   (in_use[g]),
			.page     (page_s1),
			.scan_in  (chain[g]),
			.scan_out (chain[g+1]),
			.upd      (upd)
		);
	end

	// Replacement decision: hit, else first empty frame, else oldest frame.
	assign last   = chain[FRAMES];
	assign is_hit = last.hit_found;
	assign evict  = !last.hit_found && !last.empty_found;

	always_comb begin
		priority if (last.hit_found) begin
			tgt = last.hit_idx;
		end else if (last.empty_found) begin
			tgt = last.empty_idx;
		end else begin
			tgt = last.best_idx;
		end
	end

	always_comb begin
		upd.en         = fire;
		upd.tgt        = tgt;
		upd.age_all    = !last.hit_found && last.empty_found;
		upd.limit      = last.hit_found ? last.hit_rank : last.best_rank;
		upd.write_page = !last.hit_found;
	end

	// Saturating hit and fault counters.
	assign hit_cnt_next   = (is_hit && hit_cnt_q != '1) ? hit_cnt_q + 1'b1 : hit_cnt_q;
	assign fault_cnt_next = (!is_hit && fault_cnt_q != '1) ?
		fault_cnt_q + 1'b1 : fault_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_cnt_q   <= '0;
			fault_cnt_q <= '0;
		end else if (fire) begin
			hit_cnt_q   <= hit_cnt_next;
			fault_cnt_q <= fault_cnt_next;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_hit_q      <= is_hit;
			rsp_frame_q    <= tgt;
			rsp_ev_valid_q <= evict;
			rsp_ev_page_q  <= evict ? last.best_page : '0;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.hit           = rsp_hit_q;
	assign rsp.frame         = rsp_frame_q;
	assign rsp.evicted_valid = rsp_ev_valid_q;
	assign rsp.evicted_page  = rsp_ev_page_q;
	assign rsp.hit_count     = hit_cnt_q;
	assign rsp.fault_count   = fault_cnt_q;

	// A hit and an eviction never come together.
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.hit && rsp.evicted_valid))
		else $error("result reports both a hit and an eviction");

	// Without an eviction the evicted page reads as zero.
	a_ev_page_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.evicted_valid) |-> (rsp.evicted_page == '0))
		else $error("evicted page set without an eviction");

	// A matching frame is always one that takes part.
	a_hit_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && last.hit_found) |-> in_use[last.hit_idx])
		else $error("hit on a frame outside the in-use set");

	// A hit leaves the hit counter nonzero.
	a_hit_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && is_hit) |=> (hit_cnt_q != '0))
		else $error("hit not counted");

	// The lookup stage keeps its request while the result is stalled.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_free) |=> (valid_s1 && $stable(page_s1)))
		else $error("lookup stage lost a stalled request");

endmodule

`default_nettype wire
